/* src/audio_mixer_peak_meter_assert.svh */
// Assertion macros shared by the audio mixer and peak meter RTL.
`ifndef AUDIO_MIXER_PEAK_METER_ASSERT_SVH
`define AUDIO_MIXER_PEAK_METER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define AMPM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define AMPM_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define AMPM_ASSERT(lbl, prop, msg)
`define AMPM_ASSERT_RST(lbl, prop, msg)
`endif
`endif

/* src/ampm_pkg.sv */
// Package with the constants and types of the audio mixer and peak meter.
package ampm_pkg;

    localparam int SAMPLE_W = 8;
    localparam int VOL_W    = 8;
    localparam int PROD_W   = 17;
    localparam int MAG_W    = 15;
    localparam int RECIP_W  = 16;
    localparam int QUOT_W   = 9;
    localparam int TICK_W   = 8;

    localparam logic [SAMPLE_W-1:0] MIDPOINT       = 8'd127;
    localparam logic [VOL_W-1:0]    VOLUME_RESET   = 8'd100;
    localparam logic [RECIP_W-1:0]  DIV100_RECIP   = 16'd41944;
    localparam int                  DIV100_SHIFT   = 22;
    localparam logic [TICK_W-1:0]   PEAK_DECAY_INTERVAL = 8'd64;

    typedef enum logic [0:0] {
        REG_FX_VOLUME     = 1'b0,
        REG_STREAM_VOLUME = 1'b1
    } t_reg_idx;

endpackage

/* src/ampm_div100.sv */
// Scales a signed sample product by one hundredth, truncating toward zero.
module ampm_div100 (
    input  logic signed [ampm_pkg::PROD_W-1:0]   i_prod,
    output logic        [ampm_pkg::SAMPLE_W-1:0] o_term
);

    logic                                                     w_neg;
    logic [ampm_pkg::PROD_W-1:0]                              w_abs;
    logic [ampm_pkg::MAG_W-1:0]                               w_mag;
    logic [ampm_pkg::MAG_W+ampm_pkg::RECIP_W-1:0]             w_scaled;
    logic [ampm_pkg::QUOT_W-1:0]                              w_quot;
    logic [ampm_pkg::QUOT_W-1:0]                              w_signed;

    // The reciprocal is exact for every magnitude below 2^15.
    assign w_neg    = i_prod[ampm_pkg::PROD_W-1];
    assign w_abs    = w_neg ? (-i_prod) : i_prod;
    assign w_mag    = w_abs[ampm_pkg::MAG_W-1:0];
    assign w_scaled = w_mag * ampm_pkg::DIV100_RECIP;
    assign w_quot   = w_scaled[ampm_pkg::DIV100_SHIFT +: ampm_pkg::QUOT_W];
    assign w_signed = w_neg ? (-w_quot) : w_quot;
    assign o_term   = w_signed[ampm_pkg::SAMPLE_W-1:0];

endmodule

/* src/audio_mixer_peak_meter.sv */
// Top level of the two-source audio mixer with decaying peak meter.
//
// Input channel: i_valid/o_ready carry one sample tick per transaction, with an
// effects sample and a stream sample, each qualified by its own valid flag.
// Output channel: o_valid/i_ready carry one result per tick: the mixed DAC value,
// the current peak level and the finished flag.
// Configuration: i_cfg_we writes i_cfg_data to the volume register selected by
// i_cfg_index; writes take effect at once. The user must make writes only while
// the block is idle; the block itself does not enforce this. Each centered
// sample is multiplied by its volume in the accepting cycle and the product is
// registered in stage one; stage one then divides by one hundred with a
// reciprocal multiply, sums and updates the peak meter into the output register,
// which drives o_valid. Throughput: one transaction per cycle unless stalled.
// Reset clears both pipeline stages, the peak level and the decay counter, and
// sets both volumes to 100 percent.
// When the receiver stalls, the pipeline holds and o_ready drops once both
// stages are full; no transaction is lost.
`include "audio_mixer_peak_meter_assert.svh"
module audio_mixer_peak_meter (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [0:0]                      i_cfg_index,
    input  logic [ampm_pkg::VOL_W-1:0]      i_cfg_data,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic                            i_fx_valid,
    input  logic [ampm_pkg::SAMPLE_W-1:0]   i_fx_sample,
    input  logic                            i_stream_valid,
    input  logic [ampm_pkg::SAMPLE_W-1:0]   i_stream_sample,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [ampm_pkg::SAMPLE_W-1:0]   o_dac_value,
    output logic [ampm_pkg::SAMPLE_W-1:0]   o_peak_level,
    output logic                            o_finished
);

    logic [ampm_pkg::VOL_W-1:0]             r_fx_volume;
    logic [ampm_pkg::VOL_W-1:0]             r_stream_volume;

    logic                                   r_s1_valid;
    logic signed [ampm_pkg::PROD_W-1:0]     r_fx_prod;
    logic signed [ampm_pkg::PROD_W-1:0]     r_st_prod;
    logic                                   r_s1_idle;

    logic                                   r_out_valid;
    logic [ampm_pkg::SAMPLE_W-1:0]          r_dac;
    logic                                   r_finished;
    logic [ampm_pkg::SAMPLE_W-1:0]          r_peak;
    logic [ampm_pkg::TICK_W-1:0]            r_ticks;

    logic                                   w_accept;
    logic                                   w_s1_move;
    logic signed [ampm_pkg::SAMPLE_W:0]     w_fx_centred;
    logic signed [ampm_pkg::SAMPLE_W:0]     w_st_centred;
    logic signed [2*ampm_pkg::SAMPLE_W+1:0] w_fx_full;
    logic signed [2*ampm_pkg::SAMPLE_W+1:0] w_st_full;
    logic [ampm_pkg::SAMPLE_W-1:0]          w_fx_term;
    logic [ampm_pkg::SAMPLE_W-1:0]          w_st_term;

    logic [ampm_pkg::SAMPLE_W-1:0]          n_dac;
    logic [ampm_pkg::SAMPLE_W-1:0]          w_dist;
    logic [ampm_pkg::SAMPLE_W-1:0]          w_peak_max;
    logic [ampm_pkg::TICK_W-1:0]            w_ticks_inc;
    logic [ampm_pkg::SAMPLE_W-1:0]          n_peak;
    logic [ampm_pkg::TICK_W-1:0]            n_ticks;
    logic                                   n_finished;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fx_volume     <= ampm_pkg::VOLUME_RESET;
            r_stream_volume <= ampm_pkg::VOLUME_RESET;
        end else if (i_cfg_we) begin
            unique case (ampm_pkg::t_reg_idx'(i_cfg_index))
                ampm_pkg::REG_FX_VOLUME:     r_fx_volume     <= i_cfg_data;
                ampm_pkg::REG_STREAM_VOLUME: r_stream_volume <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_s1_move = r_s1_valid && (!r_out_valid || i_ready);
    assign o_ready   = !r_s1_valid || w_s1_move;
    assign w_accept  = i_valid && o_ready;

    assign w_fx_centred = $signed({1'b0, i_fx_sample}) - $signed({1'b0, ampm_pkg::MIDPOINT});
    assign w_st_centred = $signed({1'b0, i_stream_sample})
                        - $signed({1'b0, ampm_pkg::MIDPOINT});
    assign w_fx_full    = w_fx_centred * $signed({1'b0, r_fx_volume});
    assign w_st_full    = w_st_centred * $signed({1'b0, r_stream_volume});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_accept) begin
            r_s1_valid <= 1'b1;
        end else if (w_s1_move) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_fx_prod <= i_fx_valid ? w_fx_full[ampm_pkg::PROD_W-1:0] : '0;
            r_st_prod <= i_stream_valid ? w_st_full[ampm_pkg::PROD_W-1:0] : '0;
            r_s1_idle <= !i_fx_valid && !i_stream_valid;
        end
    end

    ampm_div100 u_fx_div (
        .i_prod (r_fx_prod),
        .o_term (w_fx_term)
    );

    ampm_div100 u_st_div (
        .i_prod (r_st_prod),
        .o_term (w_st_term)
    );

    always_comb begin
        n_dac       = ampm_pkg::MIDPOINT + w_fx_term + w_st_term;
        w_dist      = (n_dac > ampm_pkg::MIDPOINT) ? (n_dac - ampm_pkg::MIDPOINT)
                                                   : (ampm_pkg::MIDPOINT - n_dac);
        w_peak_max  = (r_peak < w_dist) ? w_dist : r_peak;
        w_ticks_inc = r_ticks + 1'b1;
        n_ticks     = w_ticks_inc;
        n_peak      = w_peak_max;
        if (w_ticks_inc == ampm_pkg::PEAK_DECAY_INTERVAL) begin
            n_ticks = '0;
            if (w_peak_max != '0) begin
                n_peak = w_peak_max - 1'b1;
            end
        end
        n_finished  = r_s1_idle && (n_peak == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_peak      <= '0;
            r_ticks     <= '0;
        end else begin
            if (w_s1_move) begin
                r_out_valid <= 1'b1;
                r_peak      <= n_peak;
                r_ticks     <= n_ticks;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_move) begin
            r_dac      <= n_dac;
            r_finished <= n_finished;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_dac_value  = r_dac;
    assign o_peak_level = r_peak;
    assign o_finished   = r_finished;

    `AMPM_ASSERT(a_peak_range, r_peak <= 8'd128, "Peak level exceeds 128.")
    `AMPM_ASSERT(a_tick_range, r_ticks < ampm_pkg::PEAK_DECAY_INTERVAL, "Decay counter overran.")
    `AMPM_ASSERT(a_fin_peak, (r_out_valid && r_finished) |-> (r_peak == '0), "Peak not zero.")
    `AMPM_ASSERT(a_s1_hold, (r_s1_valid && !w_s1_move) |=> r_s1_valid, "Stage one lost data.")
    `AMPM_ASSERT_RST(a_rst_clear, !i_rst_n |=> (!r_s1_valid && !r_out_valid), "Valid after reset.")

endmodule

/* tb/audio_mixer_peak_meter_tb.sv */
// Self-checking testbench for the two-source audio mixer with decaying peak meter.
module audio_mixer_peak_meter_tb;

    localparam int PERCENT     = 100;
    localparam int CYCLE_LIMIT = 200000;

    typedef struct packed {
        logic                          fx_valid;
        logic [ampm_pkg::SAMPLE_W-1:0] fx_sample;
        logic                          stream_valid;
        logic [ampm_pkg::SAMPLE_W-1:0] stream_sample;
    } t_sample_tick;

    typedef struct packed {
        logic [ampm_pkg::SAMPLE_W-1:0] dac_value;
        logic [ampm_pkg::SAMPLE_W-1:0] peak_level;
        logic                          finished;
    } t_mix_result;

    logic                          i_clk;
    logic                          i_rst_n         = 1'b0;
    logic                          i_cfg_we        = 1'b0;
    logic [0:0]                    i_cfg_index     = ampm_pkg::REG_FX_VOLUME;
    logic [ampm_pkg::VOL_W-1:0]    i_cfg_data      = '0;
    logic                          i_valid         = 1'b0;
    logic                          o_ready;
    logic                          i_fx_valid      = 1'b0;
    logic [ampm_pkg::SAMPLE_W-1:0] i_fx_sample     = '0;
    logic                          i_stream_valid  = 1'b0;
    logic [ampm_pkg::SAMPLE_W-1:0] i_stream_sample = '0;
    logic                          o_valid;
    logic                          i_ready         = 1'b0;
    logic [ampm_pkg::SAMPLE_W-1:0] o_dac_value;
    logic [ampm_pkg::SAMPLE_W-1:0] o_peak_level;
    logic                          o_finished;

    t_sample_tick pending_ticks[$];
    t_mix_result  expected_mix[$];
    t_mix_result  want;

    logic [ampm_pkg::VOL_W-1:0]    fx_gain     = ampm_pkg::VOLUME_RESET;
    logic [ampm_pkg::VOL_W-1:0]    stream_gain = ampm_pkg::VOLUME_RESET;
    logic [ampm_pkg::SAMPLE_W-1:0] meter_peak  = '0;
    logic [ampm_pkg::TICK_W-1:0]   decay_count = '0;

    int sender_idle_pct    = 0;
    int receiver_stall_pct = 0;
    int fail_count         = 0;
    int cycle_count        = 0;

    audio_mixer_peak_meter dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_fx_valid      (i_fx_valid),
        .i_fx_sample     (i_fx_sample),
        .i_stream_valid  (i_stream_valid),
        .i_stream_sample (i_stream_sample),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_dac_value     (o_dac_value),
        .o_peak_level    (o_peak_level),
        .o_finished      (o_finished)
    );

    function automatic logic [ampm_pkg::SAMPLE_W-1:0] scale_sample(
        input logic [ampm_pkg::SAMPLE_W-1:0] s,
        input logic [ampm_pkg::VOL_W-1:0]    vol);
        int centered;
        centered = int'(s) - int'(ampm_pkg::MIDPOINT);
        return ampm_pkg::SAMPLE_W'((centered * int'(vol)) / PERCENT);
    endfunction

    // Advances the mixer and peak meter state by one sample tick.
    function automatic t_mix_result mix_tick(input t_sample_tick t);
        logic [ampm_pkg::SAMPLE_W-1:0] dac;
        logic [ampm_pkg::SAMPLE_W-1:0] offset;
        t_mix_result                   r;
        dac = ampm_pkg::MIDPOINT;
        if (t.fx_valid) begin
            dac = dac + scale_sample(t.fx_sample, fx_gain);
        end
        if (t.stream_valid) begin
            dac = dac + scale_sample(t.stream_sample, stream_gain);
        end
        offset = (dac > ampm_pkg::MIDPOINT) ? dac - ampm_pkg::MIDPOINT
                                            : ampm_pkg::MIDPOINT - dac;
        if (meter_peak < offset) begin
            meter_peak = offset;
        end
        decay_count = decay_count + 1'b1;
        if (decay_count == ampm_pkg::PEAK_DECAY_INTERVAL) begin
            decay_count = '0;
            if (meter_peak != 0) begin
                meter_peak = meter_peak - 1'b1;
            end
        end
        r.dac_value  = dac;
        r.peak_level = meter_peak;
        r.finished   = !t.fx_valid && !t.stream_valid && (meter_peak == 0);
        return r;
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("audio_mixer_peak_meter_tb NOT OK");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                expected_mix.push_back(mix_tick({i_fx_valid, i_fx_sample,
                                                 i_stream_valid, i_stream_sample}));
            end
            if (!i_valid || o_ready) begin
                if (pending_ticks.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
                    {i_fx_valid, i_fx_sample, i_stream_valid, i_stream_sample}
                        <= pending_ticks.pop_front();
                    i_valid <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (expected_mix.size() == 0) begin
                    $error("result transaction with no expected result");
                    fail_count++;
                end else begin
                    want = expected_mix.pop_front();
                    if (o_dac_value !== want.dac_value) begin
                        $error("dac_value: expected %0d, got %0d", want.dac_value, o_dac_value);
                        fail_count++;
                    end
                    if (o_peak_level !== want.peak_level) begin
                        $error("peak_level: expected %0d, got %0d",
                               want.peak_level, o_peak_level);
                        fail_count++;
                    end
                    if (o_finished !== want.finished) begin
                        $error("finished: expected %0d, got %0d", want.finished, o_finished);
                        fail_count++;
                    end
                end
            end
            i_ready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    task automatic add_tick(input logic fxv, input logic [ampm_pkg::SAMPLE_W-1:0] fxs,
                            input logic stv, input logic [ampm_pkg::SAMPLE_W-1:0] sts);
        pending_ticks.push_back('{fxv, fxs, stv, sts});
    endtask

    task automatic add_random(input int count, input logic silent);
        for (int n = 0; n < count; n++) begin
            add_tick(silent ? 1'b0 : 1'($urandom_range(1)),
                     ampm_pkg::SAMPLE_W'($urandom_range(255)),
                     silent ? 1'b0 : 1'($urandom_range(1)),
                     ampm_pkg::SAMPLE_W'($urandom_range(255)));
        end
    endtask

    task automatic wait_drained();
        while (pending_ticks.size() != 0 || i_valid || expected_mix.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    task automatic write_gains(input logic [ampm_pkg::VOL_W-1:0] fx,
                               input logic [ampm_pkg::VOL_W-1:0] st);
        wait_drained();
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= ampm_pkg::REG_FX_VOLUME;
        i_cfg_data  <= fx;
        fx_gain = fx;
        @(posedge i_clk);
        i_cfg_index <= ampm_pkg::REG_STREAM_VOLUME;
        i_cfg_data  <= st;
        stream_gain = st;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // At unity gain, opposite extremes cancel so the peak stays small.
        add_tick(1'b0, 8'd0,   1'b0, 8'd0);
        add_tick(1'b0, 8'd255, 1'b0, 8'd255);
        add_tick(1'b1, 8'd127, 1'b1, 8'd127);
        add_tick(1'b0, 8'd255, 1'b0, 8'd0);
        add_tick(1'b1, 8'd0,   1'b1, 8'd255);
        add_tick(1'b1, 8'd255, 1'b1, 8'd0);
        add_tick(1'b1, 8'd0,   1'b1, 8'd254);
        add_tick(1'b1, 8'd254, 1'b1, 8'd0);
        add_tick(1'b1, 8'd127, 1'b0, 8'd0);
        add_tick(1'b0, 8'd0,   1'b1, 8'd128);
        add_tick(1'b0, 8'd0,   1'b0, 8'd255);

        // Low gains, then a long silent stretch so the peak decays to zero.
        write_gains(8'd2, 8'd1);
        sender_idle_pct = 72;
        add_random(80, 1'b0);
        add_random(260, 1'b1);
        add_random(40, 1'b0);

        write_gains(ampm_pkg::VOLUME_RESET, ampm_pkg::VOLUME_RESET);
        sender_idle_pct    = 0;
        receiver_stall_pct = 72;
        add_tick(1'b1, 8'd0,   1'b0, 8'd0);
        add_tick(1'b0, 8'd0,   1'b1, 8'd255);
        add_tick(1'b0, 8'd0,   1'b1, 8'd0);
        add_tick(1'b1, 8'd255, 1'b0, 8'd0);
        add_random(300, 1'b0);

        // Full gain pushes the sum past eight bits and it wraps.
        write_gains(8'd255, 8'd255);
        sender_idle_pct    = 38;
        receiver_stall_pct = 38;
        add_tick(1'b1, 8'd255, 1'b1, 8'd255);
        add_tick(1'b1, 8'd0,   1'b1, 8'd0);
        add_tick(1'b1, 8'd0,   1'b0, 8'd0);
        add_random(300, 1'b0);

        write_gains(8'd0, 8'd0);
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        add_random(150, 1'b0);

        write_gains(8'd37, 8'd180);
        sender_idle_pct = 72;
        add_random(300, 1'b0);

        write_gains(8'd255, 8'd1);
        sender_idle_pct    = 38;
        receiver_stall_pct = 38;
        add_random(100, 1'b0);

        wait_drained();
        repeat (4) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("audio_mixer_peak_meter_tb OK");
        end else begin
            $display("audio_mixer_peak_meter_tb NOT OK");
        end
        $finish;
    end

endmodule
